>>> rtl/odwell_pkg.sv
// ----------------------------------------------------------------------------
// odwell_pkg
// Shared types, register map, reset values and the orientation classifier
// ----------------------------------------------------------------------------
package odwell_pkg;

   typedef enum logic [2:0] {
      ORI_ERROR    = 3'd0,
      ORI_LEVEL    = 3'd1,
      ORI_TAIL     = 3'd2,
      ORI_NOSE     = 3'd3,
      ORI_LEFT     = 3'd4,
      ORI_RIGHT    = 3'd5,
      ORI_INVERTED = 3'd6
   } ori_type;

   // register map, index = paddr[4:2]
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_STRICT_LEAN  = 3'd0;
   localparam logic [2:0] REG_RELAXED_LEAN = 3'd1;
   localparam logic [2:0] REG_DWELL        = 3'd2;
   localparam logic [2:0] REG_MAX_GAP      = 3'd3;
   localparam logic [2:0] REG_TIMEOUT      = 3'd4;

   localparam logic [6:0]  RST_STRICT_LEAN  = 7'd12;
   localparam logic [6:0]  RST_RELAXED_LEAN = 7'd45;
   localparam logic [15:0] RST_DWELL        = 16'd500;
   localparam logic [15:0] RST_MAX_GAP      = 16'd1000;
   localparam logic [15:0] RST_TIMEOUT      = 16'd10000;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [6:0]  strict_lean_deg;
      logic [6:0]  relaxed_lean_deg;
      logic [15:0] dwell_ms;
      logic [15:0] max_gap_ms;
      logic [15:0] timeout_ms;
   } cfg_type;

   // one classified sample on its way to the state update
   typedef struct packed {
      logic [31:0] now_ms;
      ori_type     strict_ori;
      ori_type     relaxed_ori;
   } item_type;

   function automatic logic signed [10:0] abs11(input logic signed [10:0] v);
      abs11 = v[10] ? -v : v;
   endfunction

   function automatic ori_type classify(input logic signed [8:0] roll,
                                        input logic signed [7:0] pitch,
                                        input logic [6:0] thr);
      logic signed [10:0] r;
      logic signed [10:0] p;
      logic signed [10:0] t;
      logic               flat;
      r = 11'(roll);
      p = 11'(pitch);
      t = $signed({4'd0, thr});
      flat = abs11(p) < t;
      if (abs11(r) < t && flat) begin
         classify = ORI_LEVEL;
      end else if ((11'sd90 - p) < t) begin
         classify = ORI_TAIL;
      end else if ((11'sd90 + p) < t) begin
         classify = ORI_NOSE;
      end else if (abs11(11'sd90 + r) < t && flat) begin
         classify = ORI_LEFT;
      end else if (abs11(11'sd90 - r) < t && flat) begin
         classify = ORI_RIGHT;
      end else if ((abs11(11'sd180 - r) < t || abs11(11'sd180 + r) < t) && flat) begin
         classify = ORI_INVERTED;
      end else begin
         classify = ORI_ERROR;
      end
   endfunction

endpackage

>>> rtl/odwell_req_if.sv
// ----------------------------------------------------------------------------
// odwell_req_if
// Sample channel: timestamp, roll and pitch with valid/ready
// ----------------------------------------------------------------------------
interface odwell_req_if;
   logic              valid;
   logic              ready;
   logic [31:0]       now_ms;
   logic signed [8:0] roll_deg;
   logic signed [7:0] pitch_deg;

   modport source (output valid, output now_ms, output roll_deg, output pitch_deg,
                   input ready);
   modport sink   (input valid, input now_ms, input roll_deg, input pitch_deg,
                   output ready);
endinterface

>>> rtl/odwell_rsp_if.sv
// ----------------------------------------------------------------------------
// odwell_rsp_if
// Result channel: finished flag and held orientation with valid/ready
// ----------------------------------------------------------------------------
interface odwell_rsp_if;
   logic       valid;
   logic       ready;
   logic       finished;
   logic [2:0] orientation;

   modport source (output valid, output finished, output orientation, input ready);
   modport sink   (input valid, input finished, input orientation, output ready);
endinterface

>>> rtl/orientation_dwell_detector_top.sv
// ----------------------------------------------------------------------------
// orientation_dwell_detector_top
// Attitude sample orientation detector with dwell, gap restart and timeout
// ----------------------------------------------------------------------------
// One result beat is returned for every sample beat, in order. A sample is
// classified against both lean thresholds in the cycle it is accepted and
// enters a small queue; the state update pops one entry per cycle and
// registers the result, so the block sustains one sample per clock while the
// result side is not stalled. The sample is held in a queue entry, then its
// result in the result register. The state update (gap, elapsed time and
// dwell accumulation on 32-bit timestamps) is combinational. When the result
// side stalls, up to QUEUE_DEPTH samples plus one waiting result are buffered
// before req.ready drops. Registers must be written over APB only while no
// sample is in flight; the block itself does not enforce this.
module orientation_dwell_detector_top #(
   parameter int QUEUE_DEPTH = odwell_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   odwell_req_if.sink                          req,
   odwell_rsp_if.source                        rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [odwell_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import odwell_pkg::*;

   cfg_type  cfg;
   logic     push;
   item_type push_item;
   logic     queue_full;
   logic     q_valid;
   item_type q_item;
   logic     pop;

   odwell_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   odwell_front u_front (
      .req        (req),
      .cfg        (cfg),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   odwell_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .valid     (q_valid),
      .head      (q_item)
   );

   odwell_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_valid),
      .q_item  (q_item),
      .pop     (pop),
      .rsp     (rsp)
   );

endmodule

>>> rtl/odwell_csr.sv
// ----------------------------------------------------------------------------
// odwell_csr
// APB register file holding thresholds and timing limits
// ----------------------------------------------------------------------------
module odwell_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [odwell_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output odwell_pkg::cfg_type                 cfg
);
   import odwell_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_STRICT_LEAN:  cfg_in.strict_lean_deg  = pwdata[6:0];
            REG_RELAXED_LEAN: cfg_in.relaxed_lean_deg = pwdata[6:0];
            REG_DWELL:        cfg_in.dwell_ms         = pwdata[15:0];
            REG_MAX_GAP:      cfg_in.max_gap_ms       = pwdata[15:0];
            REG_TIMEOUT:      cfg_in.timeout_ms       = pwdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_STRICT_LEAN:  prdata = {25'd0, cfg_ff.strict_lean_deg};
         REG_RELAXED_LEAN: prdata = {25'd0, cfg_ff.relaxed_lean_deg};
         REG_DWELL:        prdata = {16'd0, cfg_ff.dwell_ms};
         REG_MAX_GAP:      prdata = {16'd0, cfg_ff.max_gap_ms};
         REG_TIMEOUT:      prdata = {16'd0, cfg_ff.timeout_ms};
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strict_lean_deg  <= RST_STRICT_LEAN;
         cfg_ff.relaxed_lean_deg <= RST_RELAXED_LEAN;
         cfg_ff.dwell_ms         <= RST_DWELL;
         cfg_ff.max_gap_ms       <= RST_MAX_GAP;
         cfg_ff.timeout_ms       <= RST_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/odwell_front.sv
// ----------------------------------------------------------------------------
// odwell_front
// Accepts samples and classifies them at both lean thresholds
// ----------------------------------------------------------------------------
module odwell_front (
   odwell_req_if.sink              req,
   input  odwell_pkg::cfg_type     cfg,
   input  logic                    queue_full,
   output logic                    push,
   output odwell_pkg::item_type    push_item
);
   import odwell_pkg::*;

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   // both classes are needed since the back end picks one by its done state
   always_comb begin
      push_item.now_ms      = req.now_ms;
      push_item.strict_ori  = classify(req.roll_deg, req.pitch_deg, cfg.strict_lean_deg);
      push_item.relaxed_ori = classify(req.roll_deg, req.pitch_deg, cfg.relaxed_lean_deg);
   end

endmodule

>>> rtl/odwell_queue.sv
// ----------------------------------------------------------------------------
// odwell_queue
// Small FIFO between the classifier and the state update
// ----------------------------------------------------------------------------
module odwell_queue #(
   parameter int DEPTH = odwell_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  odwell_pkg::item_type    push_item,
   output logic                    full,
   input  logic                    pop,
   output logic                    valid,
   output odwell_pkg::item_type    head
);
   import odwell_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   item_type         entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign valid = (count_ff != '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !valid |-> !pop)
      else $error("queue pop while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule

>>> rtl/odwell_back.sv
// ----------------------------------------------------------------------------
// odwell_back
// Dwell, gap and timeout state update with a registered result beat
// ----------------------------------------------------------------------------
module odwell_back (
   input  logic                    clock,
   input  logic                    reset,
   input  odwell_pkg::cfg_type     cfg,
   input  logic                    q_valid,
   input  odwell_pkg::item_type    q_item,
   output logic                    pop,
   odwell_rsp_if.source            rsp
);
   import odwell_pkg::*;

   logic [31:0] last_ff;
   logic [31:0] last_in;
   logic [31:0] start_ff;
   logic [31:0] start_in;
   logic [31:0] held_time_ff;
   logic [31:0] held_time_in;
   logic        done_ff;
   logic        done_in;
   ori_type     held_ori_ff;
   ori_type     held_ori_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        rsp_fin_ff;
   ori_type     rsp_ori_ff;

   logic [31:0] gap;
   logic [31:0] since_start;
   logic [31:0] held_sum;
   logic        restart;

   assign pop         = q_valid && (!rsp_valid_ff || rsp.ready);
   assign gap         = q_item.now_ms - last_ff;
   assign since_start = q_item.now_ms - start_ff;
   assign held_sum    = held_time_ff + gap;
   assign restart     = (last_ff == 32'd0) || (gap >= {16'd0, cfg.max_gap_ms});

   always_comb begin
      start_in     = start_ff;
      held_time_in = held_time_ff;
      done_in      = done_ff;
      held_ori_in  = held_ori_ff;
      last_in      = q_item.now_ms;
      if (restart) begin
         start_in     = q_item.now_ms;
         held_time_in = 32'd0;
         done_in      = 1'b0;
      end else if (!done_ff) begin
         if (since_start >= {16'd0, cfg.timeout_ms}) begin
            held_ori_in = ORI_ERROR;
            done_in     = 1'b1;
         end else if (q_item.strict_ori != ORI_ERROR) begin
            if (q_item.strict_ori == held_ori_ff) begin
               held_time_in = held_sum;
               done_in      = (held_sum >= {16'd0, cfg.dwell_ms});
            end else begin
               held_time_in = 32'd0;
            end
            held_ori_in = q_item.strict_ori;
         end
      end else begin
         start_in = q_item.now_ms;
         // leaving the held orientation at the relaxed threshold reopens detection
         if (held_ori_ff != ORI_ERROR && q_item.relaxed_ori != held_ori_ff) begin
            held_time_in = 32'd0;
            done_in      = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= 32'd0;
         start_ff     <= 32'd0;
         held_time_ff <= 32'd0;
         done_ff      <= 1'b0;
         held_ori_ff  <= ORI_ERROR;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            last_ff      <= last_in;
            start_ff     <= start_in;
            held_time_ff <= held_time_in;
            done_ff      <= done_in;
            held_ori_ff  <= held_ori_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_fin_ff <= done_in;
         rsp_ori_ff <= held_ori_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.finished    = rsp_fin_ff;
   assign rsp.orientation = rsp_ori_ff;

   a_pop_gives_beat: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp.valid)
      else $error("popped item gave no result beat");

   a_beat_tracks_state: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp.finished == done_ff) && (rsp.orientation == held_ori_ff))
      else $error("result beat differs from updated state");

   a_restart_clears_done: assert property (@(posedge clock) disable iff (reset)
      pop && restart |=> !rsp.finished && (held_time_ff == 32'd0))
      else $error("restart left detection finished");

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the orientation dwell detector
// ----------------------------------------------------------------------------
// Attitude samples go in over the request channel, and every result beat is
// compared against an in-bench model of the detector state (gap restart,
// timeout, dwell accumulation, relaxed hold). Directed tests cover the special
// cases and field extremes; random phases then run under several register
// settings with sender gaps and result-side back-pressure.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import odwell_pkg::*;

   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_ITEMS   = 305;

   typedef struct packed {
      logic    finished;
      ori_type orientation;
   } pose_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   odwell_req_if req_bus ();
   odwell_rsp_if rsp_bus ();

   orientation_dwell_detector_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // detector model state
   cfg_type   cfg;
   bit [31:0] last_call_ms;
   bit [31:0] start_ms;
   bit [31:0] held_ms;
   bit        done;
   ori_type   held_pose;

   pose_result_type expected_poses[$];

   int        error_count;
   int        sample_count;
   int        result_count;
   int        finished_count;
   int        idle_cycles;
   int        send_idle_pct;
   int        stall_pct;
   int        pose_sel;
   bit [31:0] stamp;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic ori_type pose_at(input int roll, input int pitch, input int thr);
      bit flat;
      flat = magnitude(pitch) < thr;
      if (magnitude(roll) < thr && flat) return ORI_LEVEL;
      if (90 - pitch < thr) return ORI_TAIL;
      if (90 + pitch < thr) return ORI_NOSE;
      if (magnitude(90 + roll) < thr && flat) return ORI_LEFT;
      if (magnitude(90 - roll) < thr && flat) return ORI_RIGHT;
      if ((magnitude(180 - roll) < thr || magnitude(180 + roll) < thr) && flat)
         return ORI_INVERTED;
      return ORI_ERROR;
   endfunction

   function automatic pose_result_type advance_detector(input bit [31:0] now, input int roll,
                                                        input int pitch);
      bit [31:0]       gap;
      ori_type         pose;
      pose_result_type res;
      gap = now - last_call_ms;
      if (last_call_ms == 32'd0 || gap >= 32'(cfg.max_gap_ms)) begin
         start_ms = now;
         held_ms  = 32'd0;
         done     = 1'b0;
      end else if (!done) begin
         if ((now - start_ms) >= 32'(cfg.timeout_ms)) begin
            held_pose = ORI_ERROR;
            done      = 1'b1;
         end else begin
            pose = pose_at(roll, pitch, int'(cfg.strict_lean_deg));
            if (pose != ORI_ERROR) begin
               if (pose == held_pose) begin
                  held_ms += gap;
                  if (held_ms >= 32'(cfg.dwell_ms)) done = 1'b1;
               end else begin
                  held_ms = 32'd0;
               end
               held_pose = pose;
            end
         end
      end else begin
         // finished: hold is judged against the relaxed threshold
         start_ms = now;
         if (held_pose != ORI_ERROR) begin
            pose = pose_at(roll, pitch, int'(cfg.relaxed_lean_deg));
            if (pose != held_pose) begin
               held_ms = 32'd0;
               done    = 1'b0;
            end
         end
      end
      last_call_ms    = now;
      res.finished    = done;
      res.orientation = held_pose;
      return res;
   endfunction

   always @(negedge clock) begin
      rsp_bus.ready = ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : monitor
      pose_result_type exp_res;
      bit              moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            expected_poses.push_back(advance_detector(req_bus.now_ms,
                                                      int'(req_bus.roll_deg),
                                                      int'(req_bus.pitch_deg)));
            sample_count++;
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            result_count++;
            if (expected_poses.size() == 0) begin
               error_count++;
               $display("%0t: result beat with nothing expected (finished %0d orientation %0d)",
                        $time, rsp_bus.finished, rsp_bus.orientation);
            end else begin
               exp_res = expected_poses.pop_front();
               if (exp_res.finished) finished_count++;
               if (rsp_bus.finished !== exp_res.finished) begin
                  error_count++;
                  $display("%0t: finished mismatch, expected %0d actual %0d",
                           $time, exp_res.finished, rsp_bus.finished);
               end
               if (rsp_bus.orientation !== exp_res.orientation) begin
                  error_count++;
                  $display("%0t: orientation mismatch, expected %0d actual %0d",
                           $time, exp_res.orientation, rsp_bus.orientation);
               end
            end
         end
         if (psel && penable && pready) moved = 1'b1;
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic send_sample(input bit [31:0] now, input int roll, input int pitch);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.now_ms    = now;
      req_bus.roll_deg  = roll[8:0];
      req_bus.pitch_deg = pitch[7:0];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // stop sending and wait for every outstanding result beat
   task automatic settle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_poses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input bit [31:0] value);
      bit [31:0] mask;
      bit [31:0] readback;
      mask = (idx == REG_STRICT_LEAN || idx == REG_RELAXED_LEAN) ? 32'h7F : 32'hFFFF;
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_STRICT_LEAN:  cfg.strict_lean_deg  = value[6:0];
         REG_RELAXED_LEAN: cfg.relaxed_lean_deg = value[6:0];
         REG_DWELL:        cfg.dwell_ms         = value[15:0];
         REG_MAX_GAP:      cfg.max_gap_ms       = value[15:0];
         REG_TIMEOUT:      cfg.timeout_ms       = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      readback = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if ((readback & mask) !== (value & mask)) begin
         error_count++;
         $display("%0t: register %0d readback, expected %0h actual %0h",
                  $time, idx, value & mask, readback);
      end
   endtask

   task automatic set_config(input int strict_deg, input int relaxed_deg, input int dwell,
                             input int max_gap, input int timeout);
      write_register(REG_STRICT_LEAN, strict_deg);
      write_register(REG_RELAXED_LEAN, relaxed_deg);
      write_register(REG_DWELL, dwell);
      write_register(REG_MAX_GAP, max_gap);
      write_register(REG_TIMEOUT, timeout);
   endtask

   // tail-down reached and held at reset settings, zero timestamp restarts
   task automatic test_dwell_finish();
      send_sample(32'd0, 0, 0);
      send_sample(32'd0, 0, 0);
      send_sample(32'd100, 0, 90);
      send_sample(32'd400, 0, 90);
      send_sample(32'd700, 5, 85);
      send_sample(32'd1000, -170, 88);
      send_sample(32'd1300, 40, 60);
      send_sample(32'd1600, 0, -90);
      stamp = 32'd1600;
   endtask

   // every orientation becomes the held one, then an error sample changes nothing
   task automatic test_orientation_sweep();
      int rolls[9]   = '{0, 0, 0, 0, -90, 90, 180, -180, 45};
      int pitches[9] = '{0, 0, 90, -90, 0, 0, 0, 0, 45};
      stamp += 32'd5000;
      foreach (rolls[i]) begin
         send_sample(stamp, rolls[i], pitches[i]);
         stamp += 32'd10;
      end
   endtask

   task automatic test_timeout();
      settle();
      write_register(REG_TIMEOUT, 1);
      stamp += 32'd5000;
      send_sample(stamp, 45, 0);
      send_sample(stamp + 32'd1, 45, 0);
      // finished with error held: only the start and last-sample times move
      send_sample(stamp + 32'd2, 0, 0);
      stamp += 32'd2;
      settle();
   endtask

   // zero strict threshold, zero dwell, wide relaxed threshold, timestamp wrap
   task automatic test_field_extremes();
      set_config(0, 127, 0, 65535, 65535);
      send_sample(32'hFFFF_FFF0, 0, 127);
      send_sample(32'hFFFF_FFFF, -256, -128);
      send_sample(32'h0000_0005, 255, -128);
      send_sample(32'h0000_0006, -1, 0);
      stamp = 32'd6;
      settle();
   endtask

   task automatic play_random(input int count, input bit with_pause);
      int r;
      int roll;
      int pitch;
      int lim;
      int gap_top;
      for (int i = 0; i < count; i++) begin
         if (with_pause && i == count / 2) settle();
         gap_top = int'(cfg.max_gap_ms);
         r = $urandom_range(99);
         if (r < 2) stamp = 32'd0;
         else if (r < 5) stamp += gap_top + $urandom_range(0, 5000);
         else if (r < 6) stamp = $urandom();
         else if (r < 8) stamp += gap_top;
         else if (r < 9) stamp += gap_top - 1;
         else stamp += $urandom_range(0, gap_top);
         if ($urandom_range(5) == 0) pose_sel = $urandom_range(6);
         case (pose_sel)
            0: begin roll = 0; pitch = 0; end
            1: begin roll = int'($urandom_range(0, 360)) - 180; pitch = 90; end
            2: begin roll = int'($urandom_range(0, 360)) - 180; pitch = -90; end
            3: begin roll = -90; pitch = 0; end
            4: begin roll = 90; pitch = 0; end
            5: begin roll = $urandom_range(1) ? 180 : -180; pitch = 0; end
            default: begin
               roll  = int'($urandom_range(0, 360)) - 180;
               pitch = int'($urandom_range(0, 180)) - 90;
            end
         endcase
         // noise mostly inside the strict threshold, sometimes around the relaxed one
         lim = ($urandom_range(3) == 0) ? int'(cfg.relaxed_lean_deg) + 4
                                        : int'(cfg.strict_lean_deg) + 1;
         roll  += int'($urandom_range(0, 2 * lim)) - lim;
         pitch += int'($urandom_range(0, 2 * lim)) - lim;
         if ($urandom_range(99) < 6) begin
            roll  = int'($urandom_range(0, 511)) - 256;
            pitch = int'($urandom_range(0, 255)) - 128;
         end
         send_sample(stamp, roll, pitch);
      end
      settle();
   endtask

   task automatic test_random_phases();
      int max_gap;
      int dwell;
      int timeout;

      set_config(int'(RST_STRICT_LEAN), int'(RST_RELAXED_LEAN), int'(RST_DWELL),
                 int'(RST_MAX_GAP), int'(RST_TIMEOUT));
      send_idle_pct = 0;
      stall_pct     = 0;
      play_random(PHASE_ITEMS, 1'b0);

      set_config(90, 90, 65535, 65535, 65535);
      send_idle_pct = 86;
      play_random(PHASE_ITEMS, 1'b0);

      set_config(1, 1, 1, 1, 1);
      send_idle_pct = 0;
      stall_pct     = 86;
      play_random(PHASE_ITEMS, 1'b1);

      max_gap = $urandom_range(20, 4000);
      dwell   = $urandom_range(1, 3 * max_gap);
      timeout = $urandom_range(dwell, 8 * max_gap);
      set_config($urandom_range(1, 90), $urandom_range(1, 90), dwell, max_gap, timeout);
      send_idle_pct = 22;
      stall_pct     = 22;
      play_random(PHASE_ITEMS, 1'b0);

      max_gap = $urandom_range(20, 4000);
      dwell   = $urandom_range(1, 3 * max_gap);
      timeout = $urandom_range(dwell, 8 * max_gap);
      set_config($urandom_range(1, 90), $urandom_range(1, 90), dwell, max_gap, timeout);
      send_idle_pct = 0;
      stall_pct     = 0;
      play_random(PHASE_ITEMS, 1'b0);
   endtask

   initial begin
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_bus.valid     = 1'b0;
      req_bus.now_ms    = '0;
      req_bus.roll_deg  = '0;
      req_bus.pitch_deg = '0;
      rsp_bus.ready     = 1'b1;
      error_count       = 0;
      sample_count      = 0;
      result_count      = 0;
      finished_count    = 0;
      idle_cycles       = 0;
      send_idle_pct     = 0;
      stall_pct         = 0;
      pose_sel          = 0;
      stamp             = '0;
      last_call_ms      = '0;
      start_ms          = '0;
      held_ms           = '0;
      done              = 1'b0;
      held_pose         = ORI_ERROR;
      cfg.strict_lean_deg  = RST_STRICT_LEAN;
      cfg.relaxed_lean_deg = RST_RELAXED_LEAN;
      cfg.dwell_ms         = RST_DWELL;
      cfg.max_gap_ms       = RST_MAX_GAP;
      cfg.timeout_ms       = RST_TIMEOUT;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_dwell_finish();
      test_orientation_sweep();
      test_timeout();
      test_field_extremes();
      test_random_phases();
      settle();

      $display("run covered %0d samples and %0d checked results, %0d of them finished,",
               sample_count, result_count, finished_count);
      $display("across reset, extreme and random register settings with idle and stall phases");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
